// ===== rtl/core/luma_laplacian_3x3_filter_macros.svh =====
// ----------------------------------------------------------------------------
// luma_laplacian_3x3_filter_macros
// assertion macros shared by the filter rtl
// ----------------------------------------------------------------------------
`ifndef LUMA_LAPLACIAN_3X3_FILTER_MACROS_SVH
`define LUMA_LAPLACIAN_3X3_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
// condition implies consequence in the same cycle
`define LLF_ASSERT_IMPLIES(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");
// condition implies consequence in the next cycle
`define LLF_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");
`else
`define LLF_ASSERT_IMPLIES(label, clk, rst_n, cond, cons)
`define LLF_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif

`endif

// ===== rtl/core/llf_pkg.sv =====
// ----------------------------------------------------------------------------
// llf_pkg
// types, constants and the luma function of the laplacian filter
// ----------------------------------------------------------------------------
`default_nettype none

package llf_pkg;

  // geometry
  localparam int unsigned MAX_WIDTH_DEF = 64;
  localparam int unsigned FW_W          = 7;
  localparam int unsigned FH_W          = 12;
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 7'd64;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd48;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // pixel arithmetic
  localparam int unsigned PIX_W = 8;
  localparam int unsigned RGB_W = 24;
  localparam logic [7:0] LUMA_R_COEF = 8'd77;
  localparam logic [7:0] LUMA_G_COEF = 8'd150;
  localparam logic [7:0] LUMA_B_COEF = 8'd29;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // per request control carried next to the pixel data
  typedef struct packed {
    logic has_result;
    logic border;
    logic frame_end;
  } llf_tag_t;

  // y = (77r + 150g + 29b) >> 8
  function automatic logic [PIX_W-1:0] luma_of(input logic [RGB_W-1:0] rgb);
    logic [15:0] pr;
    logic [15:0] pg;
    logic [15:0] pb;
    logic [15:0] sum;
    pr  = 16'(rgb[23:16]) * 16'(LUMA_R_COEF);
    pg  = 16'(rgb[15:8])  * 16'(LUMA_G_COEF);
    pb  = 16'(rgb[7:0])   * 16'(LUMA_B_COEF);
    sum = pr + pg + pb;
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/luma_laplacian_3x3_filter.sv =====
// ----------------------------------------------------------------------------
// luma_laplacian_3x3_filter
// rgb to luma conversion followed by a 3x3 laplacian edge filter
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the input channel (in_valid_i, in_stall_o,
// pixel_rgb_i); filtered gray pixels leave on the output channel
// (out_valid_o, out_stall_i, out_rgb_o, frame_end_o). A request moves when
// valid is high and stall is low. frame_width and frame_height are written
// through the cfg port (index 0 and 1), which is always ready; write them
// only while the stream is idle.
// One pixel is accepted per cycle while in_stall_o is low. A pixel passes
// through the line store read stage and then lands in the output register,
// where its result can be taken. The result belongs to the position one
// line and one column behind the input: the first frame_width+1 pixels
// after reset give no result, and after that every input gives one.
// Rate is set by the single line store memory, read when a pixel enters and
// written when it leaves the read stage.
// Reset clears the positions and the window and sets the geometry to 64 by
// 48; the line store is not cleared, its old content only feeds border
// pixels, which are forced to zero.
// When the receiver stalls, the output register holds its result and the
// read stage holds one more pixel; beyond that in_stall_o is raised.
// ----------------------------------------------------------------------------
`default_nettype none

`include "luma_laplacian_3x3_filter_macros.svh"

module luma_laplacian_3x3_filter
  import llf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pixel input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [RGB_W-1:0]      pixel_rgb_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [RGB_W-1:0]      out_rgb_o,
  output logic                  frame_end_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned CMP_W = ((AW > FW_W) ? AW : FW_W) + 1;
  localparam int unsigned RW    = FH_W + 1;

  // geometry registers
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;

  // positions
  logic [AW-1:0]   in_col_q, in_col_d, out_col_q, out_col_d;
  logic [FH_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic            primed_q, primed_d;

  // read stage
  logic             s1_valid_q;
  logic [AW-1:0]    s1_col_q;
  logic [PIX_W-1:0] s1_luma_q;
  llf_tag_t         s1_tag_q;
  llf_tag_t         tag_d;
  logic             s1_move;
  logic             in_acc;
  logic [2*PIX_W-1:0] rd_data;
  logic [PIX_W-1:0] gray;

  // output register
  logic             out_valid_q;
  logic [PIX_W-1:0] out_gray_q;
  logic             frame_end_q;

  // position arithmetic
  logic [CMP_W-1:0] w_eff;
  logic [RW-1:0]    h_eff;
  logic [AW-1:0]    ic, oc;
  logic [RW-1:0]    ir, orow;
  logic [RW-1:0]    row_tmp;

  // configuration port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_acc     = in_valid_i && !in_stall_o;

  // effective geometry, positions normalized, then advanced
  always_comb begin
    if (CMP_W'(frame_width_q) < CMP_W'(3)) begin
      w_eff = CMP_W'(3);
    end else if (CMP_W'(frame_width_q) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(frame_width_q);
    end
    h_eff = (frame_height_q < FH_W'(3)) ? RW'(3) : RW'(frame_height_q);

    // input position
    if (CMP_W'(in_col_q) >= w_eff) begin
      ic      = '0;
      row_tmp = RW'(in_row_q) + RW'(1);
    end else begin
      ic      = in_col_q;
      row_tmp = RW'(in_row_q);
    end
    ir = (row_tmp >= h_eff) ? '0 : row_tmp;

    primed_d = primed_q || ((ir != '0) && (ic != '0));

    if (CMP_W'(ic) + CMP_W'(1) >= w_eff) begin
      in_col_d = '0;
      in_row_d = (ir + RW'(1) >= h_eff) ? '0 : FH_W'(ir + RW'(1));
    end else begin
      in_col_d = ic + AW'(1);
      in_row_d = FH_W'(ir);
    end

    // output position
    if (CMP_W'(out_col_q) >= w_eff) begin
      oc      = '0;
      row_tmp = RW'(out_row_q) + RW'(1);
    end else begin
      oc      = out_col_q;
      row_tmp = RW'(out_row_q);
    end
    orow = (row_tmp >= h_eff) ? '0 : row_tmp;

    tag_d.has_result = primed_d;
    tag_d.border     = (orow == '0) || (orow + RW'(1) >= h_eff) ||
                       (oc == '0) || (CMP_W'(oc) + CMP_W'(1) >= w_eff);
    tag_d.frame_end  = (orow + RW'(1) == h_eff) && (CMP_W'(oc) + CMP_W'(1) == w_eff);

    if (!primed_d) begin
      out_col_d = oc;
      out_row_d = FH_W'(orow);
    end else if (CMP_W'(oc) + CMP_W'(1) >= w_eff) begin
      out_col_d = '0;
      out_row_d = (orow + RW'(1) >= h_eff) ? '0 : FH_W'(orow + RW'(1));
    end else begin
      out_col_d = oc + AW'(1);
      out_row_d = FH_W'(orow);
    end
  end

  // position registers, updated per accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      primed_q  <= 1'b0;
    end else if (in_acc) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      primed_q  <= primed_d;
    end
  end

  // read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q  <= ic;
      s1_luma_q <= luma_of(pixel_rgb_i);
      s1_tag_q  <= tag_d;
    end
  end

  // line stores: read on entry, shift lines on exit
  llf_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (ic),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_move),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({rd_data[PIX_W-1:0], s1_luma_q})
  );

  // window and laplacian
  llf_kernel u_kernel (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (s1_move),
    .top_i    (rd_data[2*PIX_W-1:PIX_W]),
    .mid_i    (rd_data[PIX_W-1:0]),
    .luma_i   (s1_luma_q),
    .border_i (s1_tag_q.border),
    .gray_o   (gray)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move && s1_tag_q.has_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_tag_q.has_result) begin
      out_gray_q  <= gray;
      frame_end_q <= s1_tag_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rgb_o   = {out_gray_q, out_gray_q, out_gray_q};
  assign frame_end_o = frame_end_q;

  // checks
  `LLF_ASSERT_IMPLIES(a_result_after_primed, clk_i, rst_ni, out_valid_q, primed_q)
  `LLF_ASSERT_IMPLIES(a_frame_end_border, clk_i, rst_ni, out_valid_o && frame_end_o, out_rgb_o == '0)
  `LLF_ASSERT_NEXT(a_stall_holds_stage, clk_i, rst_ni, in_stall_o, s1_valid_q)

endmodule

`default_nettype wire

// ===== rtl/core/llf_line_store.sv =====
// ----------------------------------------------------------------------------
// llf_line_store
// two line stores of luma packed in one memory, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module llf_line_store
  import llf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int unsigned AW        = $clog2(MAX_WIDTH)
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [2*PIX_W-1:0]   rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [2*PIX_W-1:0]   wr_data_i
);

  // entry layout: older line in the upper byte, newer line in the lower byte
  logic [2*PIX_W-1:0] mem_q [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/llf_kernel.sv =====
// ----------------------------------------------------------------------------
// llf_kernel
// 3x3 luma window and laplacian with clamp to 0..255
// ----------------------------------------------------------------------------
`default_nettype none

module llf_kernel
  import llf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [PIX_W-1:0] top_i,
  input  logic [PIX_W-1:0] mid_i,
  input  logic [PIX_W-1:0] luma_i,
  input  logic             border_i,
  output logic [PIX_W-1:0] gray_o
);

  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] win_d [9];
  logic [10:0]      nb_sum;
  logic signed [11:0] acc;
  logic [PIX_W-1:0] edge_val;

  // next window: each row moves left, new column enters on the right
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k*3]   = win_q[k*3+1];
      win_d[k*3+1] = win_q[k*3+2];
    end
    win_d[2] = top_i;
    win_d[5] = mid_i;
    win_d[8] = luma_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  // 8 * centre minus the eight neighbours of the shifted window
  always_comb begin
    nb_sum = 11'(win_d[0]) + 11'(win_d[1]) + 11'(win_d[2]) + 11'(win_d[3])
           + 11'(win_d[5]) + 11'(win_d[6]) + 11'(win_d[7]) + 11'(win_d[8]);
    acc    = $signed({1'b0, win_d[4], 3'b000}) - $signed({1'b0, nb_sum});
    if (acc < 0) begin
      edge_val = '0;
    end else if (acc > $signed({4'b0000, PIX_MAX})) begin
      edge_val = PIX_MAX;
    end else begin
      edge_val = acc[PIX_W-1:0];
    end
  end

  // border positions of the output frame read as zero
  assign gray_o = border_i ? '0 : edge_val;

endmodule

`default_nettype wire
